// ===== hdl/kpu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpu_pkg
// Shared types, widths and the factorial table for the permutation unranker.
// ----------------------------------------------------------------------------
package kpu_pkg;

    localparam int DIGIT_W   = 4;
    localparam int RANK_W    = 19;
    localparam int FACT_W    = 32;
    localparam int MAX_N_DEF = 9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STEP
    } t_state;

    typedef struct packed {
        logic load;
        logic err;
        logic init;
        logic sub;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic ge;
        logic last;
    } t_sts;

    function automatic logic [FACT_W-1:0] fact_of(input logic [DIGIT_W-1:0] m);
        logic [FACT_W-1:0] f;
        case (m)
            4'd0:    f = 32'd1;
            4'd1:    f = 32'd1;
            4'd2:    f = 32'd2;
            4'd3:    f = 32'd6;
            4'd4:    f = 32'd24;
            4'd5:    f = 32'd120;
            4'd6:    f = 32'd720;
            4'd7:    f = 32'd5040;
            4'd8:    f = 32'd40320;
            4'd9:    f = 32'd362880;
            4'd10:   f = 32'd3628800;
            4'd11:   f = 32'd39916800;
            4'd12:   f = 32'd479001600;
            default: f = 32'd0;
        endcase
        return f;
    endfunction

endpackage

// ===== hdl/kpu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpu_ctrl
// Sequencer: range check, then one subtract or emit step per cycle.
// ----------------------------------------------------------------------------
module kpu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  kpu_pkg::t_sts i_sts,
    output kpu_pkg::t_cmd o_cmd
);

    kpu_pkg::t_state r_state;
    kpu_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kpu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            kpu_pkg::ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = kpu_pkg::ST_CHECK;
                end
            end
            kpu_pkg::ST_CHECK: begin
                if (i_sts.bad) begin
                    o_cmd.err = 1'b1;
                    n_state   = kpu_pkg::ST_IDLE;
                end else begin
                    o_cmd.init = 1'b1;
                    n_state    = kpu_pkg::ST_STEP;
                end
            end
            kpu_pkg::ST_STEP: begin
                if (i_sts.ge) begin
                    o_cmd.sub = 1'b1;
                end else begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last) begin
                        n_state = kpu_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = kpu_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != kpu_pkg::ST_IDLE);

endmodule

// ===== hdl/kpu_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpu_dpath
// Remaining rank, used-symbol mask, symbol pointer and result registers.
// ----------------------------------------------------------------------------
module kpu_dpath #(
    parameter int MAX_N = kpu_pkg::MAX_N_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [kpu_pkg::DIGIT_W-1:0] i_digit_count,
    input  logic [kpu_pkg::RANK_W-1:0]  i_rank,
    input  kpu_pkg::t_cmd               i_cmd,
    output kpu_pkg::t_sts               o_sts,
    output logic                        o_valid,
    output logic [kpu_pkg::DIGIT_W-1:0] o_digit,
    output logic                        o_last,
    output logic                        o_bad_rank
);

    localparam int DW = kpu_pkg::DIGIT_W;
    localparam int RW = kpu_pkg::RANK_W;
    localparam int FW = kpu_pkg::FACT_W;

    logic [DW-1:0]    r_n;
    logic [RW-1:0]    r_rank;
    logic [RW-1:0]    r_rem;
    logic [DW-1:0]    r_left;
    logic [MAX_N-1:0] r_mask;
    logic [DW-1:0]    r_ptr;
    logic             r_valid;
    logic [DW-1:0]    r_digit;
    logic             r_last;
    logic             r_bad;

    logic [FW-1:0]    fac;
    logic [FW-1:0]    lim;
    logic [MAX_N-1:0] emit_mask;
    logic [DW-1:0]    next_after;
    logic [DW-1:0]    first_free;

    assign fac = kpu_pkg::fact_of(r_left - DW'(1));
    assign lim = kpu_pkg::fact_of(r_n);
    assign emit_mask = r_mask | (MAX_N'(1) << (r_ptr - DW'(1)));

    assign o_sts.bad  = (r_n == '0) || (r_n > DW'(MAX_N)) || (r_rank == '0) ||
                        ({{(FW-RW){1'b0}}, r_rank} > lim);
    assign o_sts.ge   = ({{(FW-RW){1'b0}}, r_rem} >= fac);
    assign o_sts.last = (r_left == DW'(1));

    // smallest unused symbol above the pointer
    always_comb begin
        logic found;
        found      = 1'b0;
        next_after = '0;
        for (int i = 0; i < MAX_N; i++) begin
            if (!found && !r_mask[i] && (DW'(i + 1) > r_ptr)) begin
                found      = 1'b1;
                next_after = DW'(i + 1);
            end
        end
    end

    // smallest unused symbol once the current one is taken
    always_comb begin
        logic found;
        found      = 1'b0;
        first_free = '0;
        for (int i = 0; i < MAX_N; i++) begin
            if (!found && !emit_mask[i]) begin
                found      = 1'b1;
                first_free = DW'(i + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.err | i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n    <= i_digit_count;
            r_rank <= i_rank;
        end
        if (i_cmd.init) begin
            r_rem  <= r_rank - RW'(1);
            r_left <= r_n;
            r_mask <= '0;
            r_ptr  <= DW'(1);
        end
        if (i_cmd.sub) begin
            r_rem <= r_rem - fac[RW-1:0];
            r_ptr <= next_after;
        end
        if (i_cmd.emit) begin
            r_mask  <= emit_mask;
            r_left  <= r_left - DW'(1);
            r_ptr   <= first_free;
            r_digit <= r_ptr;
            r_last  <= (r_left == DW'(1));
            r_bad   <= 1'b0;
        end
        if (i_cmd.err) begin
            r_digit <= '0;
            r_last  <= 1'b1;
            r_bad   <= 1'b1;
        end
    end

    assign o_valid    = r_valid;
    assign o_digit    = r_digit;
    assign o_last     = r_last;
    assign o_bad_rank = r_bad;

endmodule

// ===== hdl/kth_permutation_unrank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_permutation_unrank
// Gives the k-th lexicographic permutation of 1..n, one symbol per result.
// ----------------------------------------------------------------------------
// Input: i_digit_count (n) and i_rank (one-based k) are taken at a clock edge
// with start high and busy low. busy stays high until the final result.
// Output: each result is shown for one cycle with o_valid high; o_last marks
// the final symbol. A rank of zero or above n!, or n outside 1..MAX_N, gives
// one result with o_digit = 0, o_last = 1, o_bad_rank = 1.
// Steps: a range check step first, then per position one subtract step per
// unit of that position's factorial digit (subtract and step to the next
// unused symbol) plus one emit step. An error item ends after the range
// check. The shared subtract/compare loop sets the item time. The first
// result is registered from the first emit step at the earliest; an error
// result is registered from the range check.
// busy falls in the cycle the final result is shown; a new item may be taken
// at that edge. The receiver cannot stall: results are never held.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// o_valid; no item in flight survives it.
// ----------------------------------------------------------------------------
module kth_permutation_unrank #(
    parameter int MAX_N = kpu_pkg::MAX_N_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [kpu_pkg::DIGIT_W-1:0] i_digit_count,
    input  logic [kpu_pkg::RANK_W-1:0]  i_rank,
    output logic                        o_valid,
    output logic [kpu_pkg::DIGIT_W-1:0] o_digit,
    output logic                        o_last,
    output logic                        o_bad_rank
);

    kpu_pkg::t_cmd cmd;
    kpu_pkg::t_sts sts;

    kpu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    kpu_dpath #(
        .MAX_N (MAX_N)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_digit_count (i_digit_count),
        .i_rank        (i_rank),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_digit       (o_digit),
        .o_last        (o_last),
        .o_bad_rank    (o_bad_rank)
    );

endmodule

// ===== hdl/kpu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpu_checker
// Port-level checks for the permutation unranker, bound to the top level.
// ----------------------------------------------------------------------------
module kpu_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_valid,
    input logic [kpu_pkg::DIGIT_W-1:0] o_digit,
    input logic                        o_last,
    input logic                        o_bad_rank
);

    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_rank |-> o_last && (o_digit == '0))
        else $error("error item malformed");

    a_digit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_bad_rank |-> (o_digit != '0))
        else $error("zero symbol in a good item");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_valid)
        else $error("result right after final result");

    a_no_result_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> !o_valid)
        else $error("result shown as a new item begins");

endmodule

bind kth_permutation_unrank kpu_checker u_kpu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_valid    (o_valid),
    .o_digit    (o_digit),
    .o_last     (o_last),
    .o_bad_rank (o_bad_rank)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the k-th permutation unranker.
// ----------------------------------------------------------------------------
// Items (n, k) are sent with a start/busy handshake. A predictor in the bench
// builds the expected symbol sequence for each item that is taken. A monitor
// compares every strobed result, field by field, with the oldest expected one.
// The run has a directed part first: both ends of n and k, and the ranks that
// are zero or above n!. It then sends random items, most of them with valid
// ranks, under three sender idle rates.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DW    = kpu_pkg::DIGIT_W;
    localparam int RW    = kpu_pkg::RANK_W;
    localparam int N_MAX = kpu_pkg::MAX_N_DEF;

    typedef struct {
        logic [DW-1:0] digit;
        logic          last;
        logic          bad_rank;
    } t_symbol_out;

    logic          i_clk         = 1'b0;
    logic          i_rst_n       = 1'b0;
    logic          start         = 1'b0;
    logic [DW-1:0] i_digit_count = '0;
    logic [RW-1:0] i_rank        = '0;
    logic          busy;
    logic          o_valid;
    logic [DW-1:0] o_digit;
    logic          o_last;
    logic          o_bad_rank;

    t_symbol_out   pending_symbols[$];
    int            error_count     = 0;
    int            sender_idle_pct = 0;

    kth_permutation_unrank dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_digit_count (i_digit_count),
        .i_rank        (i_rank),
        .o_valid       (o_valid),
        .o_digit       (o_digit),
        .o_last        (o_last),
        .o_bad_rank    (o_bad_rank)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint unsigned factorial(input int unsigned m);
        longint unsigned f;
        f = 1;
        for (int unsigned i = 2; i <= m; i++) begin
            f = f * i;
        end
        return f;
    endfunction

    function automatic void queue_symbol(input t_symbol_out s);
        pending_symbols.insert(pending_symbols.size(), s);
    endfunction

    function automatic void predict_permutation(input logic [DW-1:0] n,
                                                input logic [RW-1:0] k);
        longint unsigned fac;
        longint unsigned rem;
        longint unsigned idx;
        int unsigned     seen;
        int unsigned     left;
        logic [15:0]     used;
        logic [DW-1:0]   pick;
        t_symbol_out     sym_out;
        if (n == 0 || n > N_MAX || k == 0 || k > factorial(n)) begin
            sym_out.digit    = '0;
            sym_out.last     = 1'b1;
            sym_out.bad_rank = 1'b1;
            queue_symbol(sym_out);
            return;
        end
        rem  = k - 1;
        fac  = factorial(n - 1);
        left = n;
        used = '0;
        for (int unsigned pos = 0; pos < n; pos++) begin
            idx  = rem / fac;
            rem  = rem % fac;
            seen = 0;
            pick = '0;
            for (int unsigned s = 1; s <= n; s++) begin
                if (!used[s] && pick == 0) begin
                    if (seen == idx) begin
                        pick = s[DW-1:0];
                    end else begin
                        seen++;
                    end
                end
            end
            if (pick != 0) begin
                used[pick] = 1'b1;
            end
            sym_out.digit    = pick;
            sym_out.last     = (pos + 1 == n);
            sym_out.bad_rank = 1'b0;
            queue_symbol(sym_out);
            left--;
            if (left > 0) begin
                fac = fac / left;
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("tb: mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    // start stays high after acceptance so back-to-back items need no toggle
    task automatic send_item(input logic [DW-1:0] n, input logic [RW-1:0] k);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_digit_count <= n;
        i_rank        <= k;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        predict_permutation(n, k);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_symbols.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_symbol_out want;
        if (i_rst_n && o_valid) begin
            if (pending_symbols.size() == 0) begin
                report_mismatch("unexpected result digit", int'(o_digit), 0);
            end else begin
                want = pending_symbols.pop_front();
                if (o_digit !== want.digit)
                    report_mismatch("digit", int'(o_digit), int'(want.digit));
                if (o_last !== want.last)
                    report_mismatch("last", int'(o_last), int'(want.last));
                if (o_bad_rank !== want.bad_rank)
                    report_mismatch("bad_rank", int'(o_bad_rank), int'(want.bad_rank));
            end
        end
    end

    task automatic test_directed_edges();
        sender_idle_pct = 25;
        send_item(4'd1, 19'd1);
        send_item(4'd1, 19'd0);
        send_item(4'd1, 19'd2);
        send_item(4'd2, 19'd1);
        send_item(4'd2, 19'd2);
        send_item(4'd2, 19'd3);
        for (int r = 1; r <= 6; r++) begin
            send_item(4'd3, r[RW-1:0]);
        end
        send_item(4'd5, 19'd120);
        send_item(4'd5, 19'd121);
        send_item(4'd8, 19'd40320);
        send_item(4'd9, 19'd1);
        send_item(4'd9, 19'd362880);
        send_item(4'd9, 19'd362881);
        send_item(4'd9, 19'd0);
        send_item(4'd9, 19'd524287);
        send_item(4'd0, 19'd1);
        send_item(4'd10, 19'd1);
        send_item(4'd15, 19'd524287);
        send_item(4'd7, 19'd2500);
        drain_results();
    endtask

    task automatic test_random_ranks(input int idle_pct, input int count);
        logic [DW-1:0] n;
        logic [RW-1:0] k;
        int            pick;
        sender_idle_pct = idle_pct;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            n    = DW'($urandom_range(N_MAX, 1));
            if (pick < 82) begin
                k = RW'($urandom_range(32'(factorial(n)), 1));
            end else if (pick < 86) begin
                k = '0;
            end else if (pick < 91) begin
                k = RW'(factorial(n) + 1);
            end else begin
                n = DW'($urandom());
                k = RW'($urandom());
            end
            send_item(n, k);
        end
        drain_results();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_edges();
        test_random_ranks(25, 66);
        test_random_ranks(67, 66);
        test_random_ranks(0, 66);
        repeat (60) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("tb: failure");
        $finish;
    end

endmodule
